FILE: rtl/core/esrc_pkg.sv
// Shared types and constants of the raw sensor compensation core.
`timescale 1ns / 1ps

package esrc_pkg;

   // Width of the pressure dividend and of the quotient.
   localparam int NUM_W = 64;
   // Magnitude width of the pressure divisor (an arithmetic shift by 33 of a 64-bit value).
   localparam int DEN_W = 31;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_TEMP       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_PRESS_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_PRESS_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_MIXED      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_HUM        = 3'd4;

   // Upper clamp of the Q10.22 humidity value.
   localparam logic [31:0] HUM_CLAMP = 32'd419430400;

   // Everything that rides alongside the divider.
   typedef struct packed {
      logic signed [31:0] temperature;
      logic [13:0]        humidity;
      logic               pvalid;
      logic               neg;
   } div_side_type;

endpackage

FILE: rtl/core/esrc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module esrc_div #(
   parameter int SideW = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [esrc_pkg::NUM_W-1:0]    in_num,
   input  logic [esrc_pkg::DEN_W-1:0]    in_den,
   input  logic [SideW-1:0]              in_side,
   output logic                          out_valid,
   output logic [esrc_pkg::NUM_W-1:0]    out_quot,
   output logic [SideW-1:0]              out_side
);

   localparam int Steps = esrc_pkg::NUM_W;
   localparam int DenW  = esrc_pkg::DEN_W;

   logic [Steps-1:0]             vld_ff;
   logic [Steps-1:0][Steps-1:0]  nq_ff;
   logic [Steps-1:0][DenW-1:0]   rem_ff;
   logic [Steps-1:0][DenW-1:0]   den_ff;
   logic [Steps-1:0][SideW-1:0]  side_ff;

   logic [Steps-1:0][Steps-1:0]  src_nq;
   logic [Steps-1:0][DenW-1:0]   src_rem;
   logic [Steps-1:0][DenW-1:0]   src_den;
   logic [Steps-1:0][SideW-1:0]  src_side;
   logic [Steps-1:0][DenW:0]     trial;
   logic [Steps-1:0][DenW:0]     diff;
   logic [Steps-1:0]             ge;
   logic [Steps-1:0][Steps-1:0]  nq_in;
   logic [Steps-1:0][DenW-1:0]   rem_in;

   // Each stage shifts one dividend bit into the partial remainder and
   // shifts the resulting quotient bit into the low end of the same word.
   always_comb begin
      for (int k = 0; k < Steps; k++) begin
         if (k == 0) begin
            src_nq[k]   = in_num;
            src_rem[k]  = '0;
            src_den[k]  = in_den;
            src_side[k] = in_side;
         end else begin
            src_nq[k]   = nq_ff[k-1];
            src_rem[k]  = rem_ff[k-1];
            src_den[k]  = den_ff[k-1];
            src_side[k] = side_ff[k-1];
         end
         trial[k]  = {src_rem[k], src_nq[k][Steps-1]};
         diff[k]   = trial[k] - {1'b0, src_den[k]};
         ge[k]     = (trial[k] >= {1'b0, src_den[k]});
         rem_in[k] = ge[k] ? diff[k][DenW-1:0] : trial[k][DenW-1:0];
         nq_in[k]  = {src_nq[k][Steps-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Steps-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nq_ff   <= nq_in;
         rem_ff  <= rem_in;
         den_ff  <= src_den;
         side_ff <= src_side;
      end
   end

   assign out_valid = vld_ff[Steps-1];
   assign out_quot  = nq_ff[Steps-1];
   assign out_side  = side_ff[Steps-1];

endmodule

FILE: rtl/core/env_sensor_raw_compensation_core.sv
// Top level of the raw temperature, pressure and humidity compensation core.
`timescale 1ns / 1ps

// This core turns one raw sample (20-bit temperature code, 20-bit pressure
// code, 16-bit humidity code) into compensated temperature in 0.01 degC,
// pressure in Pa with a flag that is low when the pressure divisor is zero,
// and humidity in 0.01 %RH clamped to 0..10000, using the standard integer
// compensation and the calibration words written over the csr_ port.
// It is one pipeline of 81 register stages: 11 stages of multiply and
// shift work, a 64-stage divider that resolves one quotient bit per stage,
// and 6 stages that finish the pressure value, the last being the output
// register. A sample transfer is taken in every cycle in which the output
// register is empty or its result is being taken, so the sustained rate is
// one sample per clock when the result side never stalls. A stall on
// rsp_ready freezes the whole pipeline, so no sample is lost or repeated.
// Calibration words must only be written while no sample is in flight;
// csr_ready is always high and an index beyond the five registers is
// ignored.

module env_sensor_raw_compensation_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [19:0]                          req_raw_temp,
   input  logic [19:0]                          req_raw_press,
   input  logic [15:0]                          req_raw_hum,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [31:0]                   rsp_temperature,
   output logic [23:0]                          rsp_pressure,
   output logic                                 rsp_pressure_valid,
   output logic [13:0]                          rsp_humidity,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [esrc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [63:0]                          csr_data
);

   // ------------------------------------------------------------------
   // Calibration registers and coefficient unpacking.
   // ------------------------------------------------------------------
   logic [47:0] cal_temp_ff;
   logic [63:0] cal_press_low_ff;
   logic [63:0] cal_press_high_ff;
   logic [47:0] cal_mixed_ff;
   logic [31:0] cal_hum_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff       <= '0;
         cal_press_low_ff  <= '0;
         cal_press_high_ff <= '0;
         cal_mixed_ff      <= '0;
         cal_hum_ff        <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            esrc_pkg::CSR_CAL_TEMP:       cal_temp_ff       <= csr_data[47:0];
            esrc_pkg::CSR_CAL_PRESS_LOW:  cal_press_low_ff  <= csr_data;
            esrc_pkg::CSR_CAL_PRESS_HIGH: cal_press_high_ff <= csr_data;
            esrc_pkg::CSR_CAL_MIXED:      cal_mixed_ff      <= csr_data[47:0];
            esrc_pkg::CSR_CAL_HUM:        cal_hum_ff        <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   logic [15:0]        t1;
   logic signed [31:0] t2x, t3x;
   logic [15:0]        p1;
   logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
   logic signed [31:0] h1x, h2x, h3x, h4x, h5x, h6x;

   assign t1  = cal_temp_ff[15:0];
   assign t2x = 32'($signed(cal_temp_ff[31:16]));
   assign t3x = 32'($signed(cal_temp_ff[47:32]));
   assign p1  = cal_press_low_ff[15:0];
   assign p2  = $signed(cal_press_low_ff[31:16]);
   assign p3  = $signed(cal_press_low_ff[47:32]);
   assign p4  = $signed(cal_press_low_ff[63:48]);
   assign p5  = $signed(cal_press_high_ff[15:0]);
   assign p6  = $signed(cal_press_high_ff[31:16]);
   assign p7  = $signed(cal_press_high_ff[47:32]);
   assign p8  = $signed(cal_press_high_ff[63:48]);
   assign p9  = $signed(cal_mixed_ff[15:0]);
   assign h1x = $signed({24'd0, cal_mixed_ff[23:16]});
   assign h2x = 32'($signed(cal_mixed_ff[39:24]));
   assign h3x = $signed({24'd0, cal_mixed_ff[47:40]});
   assign h4x = 32'($signed(cal_hum_ff[11:0]));
   assign h5x = 32'($signed(cal_hum_ff[23:12]));
   assign h6x = 32'($signed(cal_hum_ff[31:24]));

   // ------------------------------------------------------------------
   // Pipeline control: every stage moves together when the output
   // register is free or its transfer completes this cycle.
   // ------------------------------------------------------------------
   logic        adv;
   logic        out_vld_ff;
   logic [10:0] pre_vld_ff;
   logic [4:0]  post_vld_ff;
   logic        div_out_valid;

   assign adv       = ~out_vld_ff | rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff  <= '0;
         post_vld_ff <= '0;
         out_vld_ff  <= 1'b0;
      end else if (adv) begin
         pre_vld_ff  <= {pre_vld_ff[9:0], req_valid};
         post_vld_ff <= {post_vld_ff[3:0], div_out_valid};
         out_vld_ff  <= post_vld_ff[4];
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: the two temperature products.
   // ------------------------------------------------------------------
   logic [31:0] s1_apre, s1_d, s1_am_in, s1_dd_in;
   logic [31:0] s1_am_ff, s1_dd_ff;
   logic [19:0] s1_press_ff;
   logic [15:0] s1_hum_ff;

   always_comb begin
      s1_apre  = {15'd0, req_raw_temp[19:3]} - {15'd0, t1, 1'b0};
      s1_d     = {16'd0, req_raw_temp[19:4]} - {16'd0, t1};
      s1_am_in = s1_apre * t2x;
      s1_dd_in = s1_d * s1_d;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_am_ff    <= s1_am_in;
         s1_dd_ff    <= s1_dd_in;
         s1_press_ff <= req_raw_press;
         s1_hum_ff   <= req_raw_hum;
      end
   end

   // Stage 2: scale and apply T3.
   logic signed [31:0] s2_a_in, s2_dd12, s2_bm_in;
   logic signed [31:0] s2_a_ff, s2_bm_ff;
   logic [19:0]        s2_press_ff;
   logic [15:0]        s2_hum_ff;

   always_comb begin
      s2_a_in  = $signed(s1_am_ff) >>> 11;
      s2_dd12  = $signed(s1_dd_ff) >>> 12;
      s2_bm_in = s2_dd12 * t3x;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_a_ff     <= s2_a_in;
         s2_bm_ff    <= s2_bm_in;
         s2_press_ff <= s1_press_ff;
         s2_hum_ff   <= s1_hum_ff;
      end
   end

   // Stage 3: fine temperature.
   logic signed [31:0] s3_tf_in, s3_tf_ff;
   logic [19:0]        s3_press_ff;
   logic [15:0]        s3_hum_ff;

   assign s3_tf_in = s2_a_ff + (s2_bm_ff >>> 14);

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_tf_ff    <= s3_tf_in;
         s3_press_ff <= s2_press_ff;
         s3_hum_ff   <= s2_hum_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: temperature result, first pressure products and the first
   // humidity products, all from the fine temperature.
   // ------------------------------------------------------------------
   logic signed [31:0] s4_t5, s4_temp_in, s4_hv;
   logic signed [33:0] s4_v1;
   logic signed [67:0] s4_sqw;
   logic signed [49:0] s4_m5w, s4_m2w;
   logic [31:0]        s4_hm5_in, s4_he1_in, s4_hd1_in;
   logic signed [31:0] s4_temp_ff;
   logic [63:0]        s4_sq_ff;
   logic signed [63:0] s4_m5_ff, s4_m2_ff;
   logic [31:0]        s4_hm5_ff, s4_he1_ff, s4_hd1_ff;
   logic [19:0]        s4_press_ff;
   logic [15:0]        s4_hum_ff;

   always_comb begin
      s4_t5      = s3_tf_ff * 32'sd5 + 32'sd128;
      s4_temp_in = s4_t5 >>> 8;
      s4_v1      = 34'(s3_tf_ff) - 34'sd128000;
      s4_sqw     = s4_v1 * s4_v1;
      s4_m5w     = s4_v1 * p5;
      s4_m2w     = s4_v1 * p2;
      s4_hv      = s3_tf_ff - 32'sd76800;
      s4_hm5_in  = h5x * s4_hv;
      s4_he1_in  = s4_hv * h6x;
      s4_hd1_in  = s4_hv * h3x;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_temp_ff  <= s4_temp_in;
         s4_sq_ff    <= s4_sqw[63:0];
         s4_m5_ff    <= 64'(s4_m5w);
         s4_m2_ff    <= 64'(s4_m2w);
         s4_hm5_ff   <= s4_hm5_in;
         s4_he1_ff   <= s4_he1_in;
         s4_hd1_ff   <= s4_hd1_in;
         s4_press_ff <= s3_press_ff;
         s4_hum_ff   <= s3_hum_ff;
      end
   end

   // Stage 5: square terms times P6 and P3; humidity offset term.
   logic signed [79:0] s5_t6w, s5_t3w;
   logic [31:0]        s5_xs;
   logic signed [31:0] s5_x_in, s5_e_in, s5_d_in;
   logic [63:0]        s5_t6_ff, s5_t3_ff;
   logic signed [63:0] s5_m5_ff, s5_m2_ff;
   logic signed [31:0] s5_x_ff, s5_e_ff, s5_d_ff, s5_temp_ff;
   logic [19:0]        s5_press_ff;

   always_comb begin
      s5_t6w  = $signed(s4_sq_ff) * p6;
      s5_t3w  = $signed(s4_sq_ff) * p3;
      s5_xs   = {2'd0, s4_hum_ff, 14'd0} - (h4x << 20) - s4_hm5_ff + 32'd16384;
      s5_x_in = $signed(s5_xs) >>> 15;
      s5_e_in = $signed(s4_he1_ff) >>> 10;
      s5_d_in = ($signed(s4_hd1_ff) >>> 11) + 32'sd32768;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_t6_ff    <= s5_t6w[63:0];
         s5_t3_ff    <= s5_t3w[63:0];
         s5_m5_ff    <= s4_m5_ff;
         s5_m2_ff    <= s4_m2_ff;
         s5_x_ff     <= s5_x_in;
         s5_e_ff     <= s5_e_in;
         s5_d_ff     <= s5_d_in;
         s5_temp_ff  <= s4_temp_ff;
         s5_press_ff <= s4_press_ff;
      end
   end

   // Stage 6: pressure sums var2 and var1; humidity product.
   logic signed [63:0] s6_v2_in, s6_v1b_in, s6_v2_ff, s6_v1b_ff;
   logic signed [31:0] s6_em_in, s6_em_ff, s6_x_ff, s6_temp_ff;
   logic [19:0]        s6_press_ff;

   always_comb begin
      s6_v2_in  = $signed(s5_t6_ff) + (s5_m5_ff <<< 17) + (64'(p4) <<< 35);
      s6_v1b_in = ($signed(s5_t3_ff) >>> 8) + (s5_m2_ff <<< 12);
      s6_em_in  = s5_e_ff * s5_d_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_v2_ff    <= s6_v2_in;
         s6_v1b_ff   <= s6_v1b_in;
         s6_em_ff    <= s6_em_in;
         s6_x_ff     <= s5_x_ff;
         s6_temp_ff  <= s5_temp_ff;
         s6_press_ff <= s5_press_ff;
      end
   end

   // Stage 7: divisor product with P1 and the scaled dividend; humidity product with H2.
   logic [63:0]        s7_w, s7_diff;
   logic [79:0]        s7_v1cw;
   logic [20:0]        s7_pi;
   logic [75:0]        s7_numw;
   logic signed [31:0] s7_e2, s7_ehm_in;
   logic [63:0]        s7_v1c_ff, s7_num_ff;
   logic signed [31:0] s7_ehm_ff, s7_x_ff, s7_temp_ff;

   always_comb begin
      s7_w      = s6_v1b_ff + 64'h0000_8000_0000_0000;
      s7_v1cw   = s7_w * p1;
      s7_pi     = 21'd1048576 - {1'b0, s6_press_ff};
      s7_diff   = {12'd0, s7_pi, 31'd0} - s6_v2_ff;
      s7_numw   = s7_diff * 12'd3125;
      s7_e2     = (s6_em_ff >>> 10) + 32'sd2097152;
      s7_ehm_in = s7_e2 * h2x;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_v1c_ff  <= s7_v1cw[63:0];
         s7_num_ff  <= s7_numw[63:0];
         s7_ehm_ff  <= s7_ehm_in;
         s7_x_ff    <= s6_x_ff;
         s7_temp_ff <= s6_temp_ff;
      end
   end

   // Stage 8: operand magnitudes and signs for the divider; humidity core.
   logic [esrc_pkg::DEN_W-1:0] s8_den, s8_dmag_in;
   logic [63:0]                s8_nmag_in;
   logic signed [31:0]         s8_e3, s8_vv_in;
   logic [31:0]                s8_ehr;
   logic [63:0]                s8_nmag_ff;
   logic [esrc_pkg::DEN_W-1:0] s8_dmag_ff;
   logic                       s8_neg_ff, s8_pvalid_ff;
   logic signed [31:0]         s8_vv_ff, s8_temp_ff;

   always_comb begin
      s8_den     = s7_v1c_ff[63:33];
      s8_dmag_in = s8_den[esrc_pkg::DEN_W-1] ? ('0 - s8_den) : s8_den;
      s8_nmag_in = s7_num_ff[63] ? (64'd0 - s7_num_ff) : s7_num_ff;
      s8_ehr     = s7_ehm_ff + 32'd8192;
      s8_e3      = $signed(s8_ehr) >>> 14;
      s8_vv_in   = s7_x_ff * s8_e3;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_nmag_ff   <= s8_nmag_in;
         s8_dmag_ff   <= s8_dmag_in;
         s8_neg_ff    <= s7_num_ff[63] ^ s8_den[esrc_pkg::DEN_W-1];
         s8_pvalid_ff <= (s8_den != '0);
         s8_vv_ff     <= s8_vv_in;
         s8_temp_ff   <= s7_temp_ff;
      end
   end

   // Stages 9 to 11: the humidity correction, clamp and scaling.
   logic signed [31:0]         s9_a15, s9_sqh_in, s9_sqh_ff, s9_vv_ff, s9_temp_ff;
   logic [63:0]                s9_nmag_ff;
   logic [esrc_pkg::DEN_W-1:0] s9_dmag_ff;
   logic                       s9_neg_ff, s9_pvalid_ff;

   assign s9_a15    = s8_vv_ff >>> 15;
   assign s9_sqh_in = s9_a15 * s9_a15;

   always_ff @(posedge clock) begin
      if (adv) begin
         s9_sqh_ff    <= s9_sqh_in;
         s9_vv_ff     <= s8_vv_ff;
         s9_temp_ff   <= s8_temp_ff;
         s9_nmag_ff   <= s8_nmag_ff;
         s9_dmag_ff   <= s8_dmag_ff;
         s9_neg_ff    <= s8_neg_ff;
         s9_pvalid_ff <= s8_pvalid_ff;
      end
   end

   logic signed [31:0]         s10_mh_in, s10_mh_ff, s10_vv_ff, s10_temp_ff;
   logic [63:0]                s10_nmag_ff;
   logic [esrc_pkg::DEN_W-1:0] s10_dmag_ff;
   logic                       s10_neg_ff, s10_pvalid_ff;

   assign s10_mh_in = (s9_sqh_ff >>> 7) * h1x;

   always_ff @(posedge clock) begin
      if (adv) begin
         s10_mh_ff     <= s10_mh_in;
         s10_vv_ff     <= s9_vv_ff;
         s10_temp_ff   <= s9_temp_ff;
         s10_nmag_ff   <= s9_nmag_ff;
         s10_dmag_ff   <= s9_dmag_ff;
         s10_neg_ff    <= s9_neg_ff;
         s10_pvalid_ff <= s9_pvalid_ff;
      end
   end

   logic signed [31:0]         s11_hv;
   logic [31:0]                s11_hc;
   logic [23:0]                s11_hs;
   esrc_pkg::div_side_type     s11_side_in, s11_side_ff;
   logic [63:0]                s11_nmag_ff;
   logic [esrc_pkg::DEN_W-1:0] s11_dmag_ff;

   always_comb begin
      s11_hv = s10_vv_ff - (s10_mh_ff >>> 4);
      // Negative values clamp to zero, large ones to 100 %RH.
      priority if (s11_hv[31]) begin
         s11_hc = '0;
      end else if ($unsigned(s11_hv) > esrc_pkg::HUM_CLAMP) begin
         s11_hc = esrc_pkg::HUM_CLAMP;
      end else begin
         s11_hc = $unsigned(s11_hv);
      end
      s11_hs                  = s11_hc[28:12] * 7'd100;
      s11_side_in.temperature = s10_temp_ff;
      s11_side_in.humidity    = s11_hs[23:10];
      s11_side_in.pvalid      = s10_pvalid_ff;
      s11_side_in.neg         = s10_neg_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s11_side_ff <= s11_side_in;
         s11_nmag_ff <= s10_nmag_ff;
         s11_dmag_ff <= s10_dmag_ff;
      end
   end

   // ------------------------------------------------------------------
   // Pressure division.
   // ------------------------------------------------------------------
   logic [63:0]                                   div_quot;
   logic [$bits(esrc_pkg::div_side_type)-1:0]     div_side_bits;
   esrc_pkg::div_side_type                        div_side;

   esrc_div #(
      .SideW ($bits(esrc_pkg::div_side_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (pre_vld_ff[10]),
      .in_num    (s11_nmag_ff),
      .in_den    (s11_dmag_ff),
      .in_side   (s11_side_ff),
      .out_valid (div_out_valid),
      .out_quot  (div_quot),
      .out_side  (div_side_bits)
   );

   assign div_side = esrc_pkg::div_side_type'(div_side_bits);

   // ------------------------------------------------------------------
   // Pressure finish: sign, P9 square term, P8 term, final offset.
   // ------------------------------------------------------------------
   esrc_pkg::div_side_type q1_side_ff, q2_side_ff, q3_side_ff, q4_side_ff, q5_side_ff;
   logic [63:0] q1_p_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         q1_p_ff    <= div_side.neg ? (64'd0 - div_quot) : div_quot;
         q1_side_ff <= div_side;
      end
   end

   logic signed [63:0] q2_p13;
   logic [63:0]        q2_ll_in;
   logic [31:0]        q2_lh_in;
   logic signed [79:0] q2_m8w;
   logic [63:0]        q2_ll_ff, q2_p_ff, q2_m8_ff;
   logic [31:0]        q2_lh_ff;

   // The square of the shifted value is built from 32-bit halves.
   always_comb begin
      q2_p13   = $signed(q1_p_ff) >>> 13;
      q2_ll_in = 64'(q2_p13[31:0]) * 64'(q2_p13[31:0]);
      q2_lh_in = q2_p13[31:0] * q2_p13[63:32];
      q2_m8w   = $signed(q1_p_ff) * p8;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q2_ll_ff   <= q2_ll_in;
         q2_lh_ff   <= q2_lh_in;
         q2_m8_ff   <= q2_m8w[63:0];
         q2_p_ff    <= q1_p_ff;
         q2_side_ff <= q1_side_ff;
      end
   end

   logic [63:0] q3_sq_ff, q3_p_ff, q3_m8_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         q3_sq_ff   <= q2_ll_ff + {q2_lh_ff[30:0], 33'd0};
         q3_p_ff    <= q2_p_ff;
         q3_m8_ff   <= q2_m8_ff;
         q3_side_ff <= q2_side_ff;
      end
   end

   logic signed [79:0] q4_tw;
   logic [63:0]        q4_t_ff, q4_p_ff, q4_m8_ff;

   assign q4_tw = $signed(q3_sq_ff) * p9;

   always_ff @(posedge clock) begin
      if (adv) begin
         q4_t_ff    <= q4_tw[63:0];
         q4_p_ff    <= q3_p_ff;
         q4_m8_ff   <= q3_m8_ff;
         q4_side_ff <= q3_side_ff;
      end
   end

   // Only the low 40 bits of the sum reach the 24-bit pascal result.
   logic [39:0] q5_s_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         q5_s_ff    <= q4_p_ff[39:0] + {q4_t_ff[63], q4_t_ff[63:25]} + q4_m8_ff[58:19];
         q5_side_ff <= q4_side_ff;
      end
   end

   logic [31:0]        out_pr;
   logic signed [31:0] out_temp_ff;
   logic [23:0]        out_press_ff;
   logic               out_pvalid_ff;
   logic [13:0]        out_hum_ff;

   assign out_pr = q5_s_ff[39:8] + (32'(p7) << 4);

   always_ff @(posedge clock) begin
      if (adv) begin
         out_temp_ff   <= q5_side_ff.temperature;
         out_press_ff  <= q5_side_ff.pvalid ? out_pr[31:8] : 24'd0;
         out_pvalid_ff <= q5_side_ff.pvalid;
         out_hum_ff    <= q5_side_ff.humidity;
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_temperature    = out_temp_ff;
   assign rsp_pressure       = out_press_ff;
   assign rsp_pressure_valid = out_pvalid_ff;
   assign rsp_humidity       = out_hum_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_press_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pressure_valid |-> rsp_pressure == 24'd0)
      else $error("pressure not zero with a zero divisor");

   a_hum_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_humidity <= 14'd10000)
      else $error("humidity above clamp");

   a_ready_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output register is empty");

endmodule
